[rtl/assert_macros.svh]
// Assertion helpers, clocked on aclk and disabled while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define FQS_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("fqs assertion failed");

// Next-cycle implication.
`define FQS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("fqs assertion failed");

`endif

[rtl/fqs_pkg.sv]
`timescale 1ns / 1ps

package fqs_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int PTR_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int WORD_W     = 32;
    localparam int POS_W      = 4;
    localparam int FILL_W     = 5;
    localparam int CMP_W      = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

    typedef enum logic [1:0] {
        FUNC_ENQ    = 2'd0,
        FUNC_DEQ    = 2'd1,
        FUNC_SEARCH = 2'd2,
        FUNC_READ   = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_FULL      = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_BAD_POS   = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_RDWAIT,
        S_SCAN,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [1:0]                func;
        logic signed [WORD_W-1:0]  value;
        logic [POS_W-1:0]          position;
    } fqs_req_t;

    typedef struct packed {
        logic [2:0]                status;
        logic signed [WORD_W-1:0]  word_out;
        logic [POS_W-1:0]          found_index;
        logic [FILL_W-1:0]         fill_count;
    } fqs_rsp_t;

    typedef struct packed {
        logic    capture;
        logic    mem_wr;
        logic    rd_issue;
        logic    rd_scan;
        logic    deq;
        logic    set_res;
        status_t res_status;
        logic    res_word;
        logic    res_found;
        logic    load_out;
    } fqs_cmd_t;

    typedef struct packed {
        func_t func;
        logic  empty;
        logic  full;
        logic  pos_bad;
        logic  scan_more;
        logic  match;
        logic  scan_last;
        logic  out_free;
    } fqs_sts_t;

endpackage

[rtl/fqs_ctrl.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fqs_ctrl
    import fqs_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  fqs_sts_t sts,
    output fqs_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                case (sts.func)
                    FUNC_ENQ: state_next = S_DONE;
                    FUNC_DEQ: state_next = sts.empty ? S_DONE : S_RDWAIT;
                    FUNC_SEARCH: state_next = sts.empty ? S_DONE : S_SCAN;
                    FUNC_READ: begin
                        state_next = (sts.empty || sts.pos_bad) ? S_DONE : S_RDWAIT;
                    end
                    default: state_next = S_DONE;
                endcase
            end
            S_RDWAIT: state_next = S_DONE;
            S_SCAN: begin
                if (sts.match || sts.scan_last) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (sts.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd            = '0;
        cmd.res_status = ST_OK;
        s_ready        = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            S_EXEC: begin
                case (sts.func)
                    FUNC_ENQ: begin
                        cmd.set_res = 1'b1;
                        if (sts.full) begin
                            cmd.res_status = ST_FULL;
                        end else begin
                            cmd.mem_wr = 1'b1;
                        end
                    end
                    FUNC_DEQ: begin
                        if (sts.empty) begin
                            cmd.set_res    = 1'b1;
                            cmd.res_status = ST_EMPTY;
                        end else begin
                            cmd.rd_issue = 1'b1;
                        end
                    end
                    FUNC_SEARCH: begin
                        if (sts.empty) begin
                            cmd.set_res    = 1'b1;
                            cmd.res_status = ST_EMPTY;
                        end
                    end
                    FUNC_READ: begin
                        if (sts.empty) begin
                            cmd.set_res    = 1'b1;
                            cmd.res_status = ST_EMPTY;
                        end else if (sts.pos_bad) begin
                            cmd.set_res    = 1'b1;
                            cmd.res_status = ST_BAD_POS;
                        end else begin
                            cmd.rd_issue = 1'b1;
                        end
                    end
                    default: begin
                        cmd.set_res = 1'b1;
                    end
                endcase
            end
            S_RDWAIT: begin
                cmd.set_res  = 1'b1;
                cmd.res_word = 1'b1;
                cmd.deq      = (sts.func == FUNC_DEQ);
            end
            S_SCAN: begin
                if (sts.match) begin
                    cmd.set_res   = 1'b1;
                    cmd.res_found = 1'b1;
                end else if (sts.scan_last) begin
                    cmd.set_res    = 1'b1;
                    cmd.res_status = ST_NOT_FOUND;
                end else if (sts.scan_more) begin
                    cmd.rd_issue = 1'b1;
                    cmd.rd_scan  = 1'b1;
                end
            end
            S_DONE: begin
                cmd.load_out = sts.out_free;
            end
            default: begin
                cmd.set_res = 1'b0;
            end
        endcase
    end

    `FQS_ASSERT_IMPL(a_scan_is_search, state_reg == S_SCAN, sts.func == FUNC_SEARCH)

endmodule

[rtl/fqs_dp.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fqs_dp
    import fqs_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  fqs_req_t s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output fqs_rsp_t m_data,
    input  fqs_cmd_t cmd,
    output fqs_sts_t sts
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    fqs_req_t              req_reg;
    logic [PTR_W-1:0]      head_reg, head_next;
    logic [PTR_W-1:0]      tail_reg, tail_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CNT_W-1:0]      rd_idx_reg, rd_idx_next;
    logic                  cmp_valid_reg, cmp_valid_next;
    logic [PTR_W-1:0]      cmp_idx_reg;
    logic [DATA_WIDTH-1:0] rdata_reg;
    status_t               res_status_reg;
    logic [WORD_W-1:0]     res_word_reg;
    logic [POS_W-1:0]      res_found_reg;
    logic                  m_valid_reg, m_valid_next;
    fqs_rsp_t              m_data_reg;

    logic [PTR_W-1:0]      rd_off;
    logic [PTR_W:0]        rd_sum;
    logic [PTR_W-1:0]      rd_addr;
    logic [DATA_WIDTH-1:0] key;
    logic [PTR_W:0]        ring_occ;
    logic [PTR_W:0]        occ_exp;

    function automatic logic [PTR_W-1:0] ring_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

    assign key = DATA_WIDTH'($unsigned(req_reg.value));

    always_comb begin
        if (cmd.rd_scan) begin
            rd_off = rd_idx_reg[PTR_W-1:0];
        end else if (func_t'(req_reg.func) == FUNC_READ) begin
            rd_off = PTR_W'(req_reg.position);
        end else begin
            rd_off = '0;
        end
        rd_sum = {1'b0, head_reg} + {1'b0, rd_off};
        if (rd_sum >= (PTR_W + 1)'(DEPTH)) begin
            rd_addr = PTR_W'(rd_sum - (PTR_W + 1)'(DEPTH));
        end else begin
            rd_addr = rd_sum[PTR_W-1:0];
        end
    end

    always_comb begin
        sts.func      = func_t'(req_reg.func);
        sts.empty     = (count_reg == '0);
        sts.full      = (count_reg >= CNT_W'(DEPTH));
        sts.pos_bad   = (CMP_W'(req_reg.position) >= CMP_W'(count_reg));
        sts.scan_more = (rd_idx_reg < count_reg);
        sts.match     = cmp_valid_reg && (rdata_reg == key);
        sts.scan_last = cmp_valid_reg && (CNT_W'(cmp_idx_reg) == count_reg - CNT_W'(1));
        sts.out_free  = !m_valid_reg || m_ready;
    end

    always_comb begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        rd_idx_next    = rd_idx_reg;
        cmp_valid_next = 1'b0;
        m_valid_next   = m_valid_reg;
        if (cmd.capture) begin
            rd_idx_next = '0;
        end
        if (cmd.mem_wr) begin
            tail_next  = ring_inc(tail_reg);
            count_next = count_reg + CNT_W'(1);
        end
        if (cmd.deq) begin
            head_next  = ring_inc(head_reg);
            count_next = count_reg - CNT_W'(1);
        end
        if (cmd.rd_scan) begin
            rd_idx_next    = rd_idx_reg + CNT_W'(1);
            cmp_valid_next = 1'b1;
        end
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            rd_idx_reg    <= '0;
            cmp_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            rd_idx_reg    <= rd_idx_next;
            cmp_valid_reg <= cmp_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mem_wr) begin
            mem[tail_reg] <= key;
        end
        if (cmd.rd_issue) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_reg <= s_data;
        end
        if (cmd.rd_scan) begin
            cmp_idx_reg <= rd_idx_reg[PTR_W-1:0];
        end
        if (cmd.set_res) begin
            res_status_reg <= cmd.res_status;
            res_word_reg   <= cmd.res_word ? WORD_W'(rdata_reg) : '0;
            res_found_reg  <= cmd.res_found ? POS_W'(cmp_idx_reg) : '0;
        end
        if (cmd.load_out) begin
            m_data_reg.status      <= res_status_reg;
            m_data_reg.word_out    <= res_word_reg;
            m_data_reg.found_index <= res_found_reg;
            m_data_reg.fill_count  <= FILL_W'(count_reg);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        if (tail_reg >= head_reg) begin
            ring_occ = {1'b0, tail_reg} - {1'b0, head_reg};
        end else begin
            ring_occ = {1'b0, tail_reg} + (PTR_W + 1)'(DEPTH) - {1'b0, head_reg};
        end
        occ_exp = (count_reg == CNT_W'(DEPTH)) ? '0 : (PTR_W + 1)'(count_reg);
    end

    `FQS_ASSERT_IMPL(a_no_overflow, cmd.mem_wr, count_reg < CNT_W'(DEPTH))
    `FQS_ASSERT_IMPL(a_no_underflow, cmd.deq, count_reg != '0)
    `FQS_ASSERT_IMPL(a_ring_matches_count, 1'b1, ring_occ == occ_exp)
    `FQS_ASSERT_IMPL(a_scan_in_range, cmp_valid_reg, CNT_W'(cmp_idx_reg) < count_reg)

endmodule

[rtl/fifo_queue_with_search.sv]
`timescale 1ns / 1ps
// Bounded FIFO queue of 32-bit words with enqueue, dequeue, search and read-at-position.
// Request beats arrive on s_valid/s_ready/s_data (func, value, position); each one
// returns exactly one result beat on m_valid/m_ready/m_data (status, word_out,
// found_index, fill_count), in request order.
// One request is processed at a time. After accept the controller enters an execute
// state; enqueue, and any request rejected as empty/full/bad position, go from there
// straight to the done state. Dequeue and read at position pass through a read-wait
// state for one registered read of the entry memory. Search passes through a scan state
// that stops at the first match or at the last entry; the scan reads one entry per cycle
// through the single memory read port. s_ready goes high again in the idle state, once
// the previous result has been loaded into the output register.
// The output register holds a result until m_ready; a stalled receiver keeps the
// block waiting with the next result pending, while s_ready stays low.
// Reset (aresetn low, synchronous) empties the queue: head, tail and count go to
// zero and no result is pending. Entry contents are not cleared.
module fifo_queue_with_search
    import fqs_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  fqs_req_t s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output fqs_rsp_t m_data
);

    fqs_cmd_t cmd;
    fqs_sts_t sts;

    fqs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    fqs_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .cmd     (cmd),
        .sts     (sts)
    );

endmodule

[bench/fifo_queue_with_search_test.sv]
`timescale 1ns / 1ps

module fifo_queue_with_search_test;
    import fqs_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 40;

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    fqs_req_t s_data = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    fqs_rsp_t m_data;

    logic [WORD_W-1:0] queue_mem [0:DEPTH-1];
    int queue_head = 0;
    int queue_tail = 0;
    int queue_fill = 0;

    fqs_rsp_t expected_rsp_q[$];
    int mismatch_count = 0;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int stall_left = 0;

    fifo_queue_with_search i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic fqs_rsp_t predict_queue_op(fqs_req_t req);
        fqs_rsp_t rsp;
        rsp = '0;
        rsp.status = ST_OK;
        case (func_t'(req.func))
            FUNC_ENQ: begin
                if (queue_fill == DEPTH) begin
                    rsp.status = ST_FULL;
                end else begin
                    queue_mem[queue_tail] = req.value;
                    queue_tail = (queue_tail + 1) % DEPTH;
                    queue_fill++;
                end
            end
            FUNC_DEQ: begin
                if (queue_fill == 0) begin
                    rsp.status = ST_EMPTY;
                end else begin
                    rsp.word_out = queue_mem[queue_head];
                    queue_head = (queue_head + 1) % DEPTH;
                    queue_fill--;
                end
            end
            FUNC_SEARCH: begin
                if (queue_fill == 0) begin
                    rsp.status = ST_EMPTY;
                end else begin
                    rsp.status = ST_NOT_FOUND;
                    for (int i = 0; i < queue_fill; i++) begin
                        if (queue_mem[(queue_head + i) % DEPTH] == req.value) begin
                            rsp.status = ST_OK;
                            rsp.found_index = POS_W'(i);
                            break;
                        end
                    end
                end
            end
            FUNC_READ: begin
                if (queue_fill == 0) begin
                    rsp.status = ST_EMPTY;
                end else if (int'(req.position) >= queue_fill) begin
                    rsp.status = ST_BAD_POS;
                end else begin
                    rsp.word_out = queue_mem[(queue_head + req.position) % DEPTH];
                end
            end
            default: begin
                rsp.status = ST_OK;
            end
        endcase
        rsp.fill_count = FILL_W'(queue_fill);
        return rsp;
    endfunction

    task automatic send_request(input fqs_req_t req);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_data  <= req;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        expected_rsp_q.push_back(predict_queue_op(req));
    endtask

    task automatic send_op(input func_t f, input logic [WORD_W-1:0] v, input logic [POS_W-1:0] p);
        fqs_req_t req;
        req.func     = f;
        req.value    = v;
        req.position = p;
        send_request(req);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_rsp_q.size() != 0) @(posedge aclk);
    endtask

    task automatic check_field(input string name, input logic [WORD_W-1:0] exp_v,
                               input logic [WORD_W-1:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin : rsp_monitor
        fqs_rsp_t exp_rsp;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_rsp_q.size() == 0) begin
                    $error("result beat with no request outstanding");
                    mismatch_count++;
                end else begin
                    exp_rsp = expected_rsp_q.pop_front();
                    check_field("status", WORD_W'(exp_rsp.status), WORD_W'(m_data.status));
                    check_field("word_out", exp_rsp.word_out, m_data.word_out);
                    check_field("found_index", WORD_W'(exp_rsp.found_index),
                                WORD_W'(m_data.found_index));
                    check_field("fill_count", WORD_W'(exp_rsp.fill_count),
                                WORD_W'(m_data.fill_count));
                end
            end
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                m_ready    <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    function automatic fqs_req_t random_request(input int enq_pct);
        fqs_req_t req;
        int r;
        req.func     = FUNC_ENQ;
        req.value    = $urandom;
        req.position = POS_W'($urandom_range(DEPTH - 1));
        if ($urandom_range(3) == 0) begin
            req.value = $urandom_range(7) - 4;
        end
        r = $urandom_range(99);
        if (r < enq_pct) begin
            req.func = FUNC_ENQ;
        end else if (r < 70) begin
            req.func = FUNC_DEQ;
        end else if (r < 85) begin
            req.func = FUNC_SEARCH;
            if (queue_fill > 0 && $urandom_range(9) < 6) begin
                req.value = queue_mem[(queue_head + $urandom_range(queue_fill - 1)) % DEPTH];
            end
        end else begin
            req.func = FUNC_READ;
            if (queue_fill > 0 && $urandom_range(9) < 7) begin
                req.position = POS_W'($urandom_range(queue_fill - 1));
            end
        end
        return req;
    endfunction

    task automatic test_empty_queue();
        send_op(FUNC_DEQ, 32'h0, 4'd0);
        send_op(FUNC_SEARCH, 32'h0, 4'd0);
        send_op(FUNC_READ, 32'hffff_ffff, 4'd15);
    endtask

    task automatic test_fill_to_full();
        send_op(FUNC_ENQ, 32'h8000_0000, 4'd0);
        send_op(FUNC_ENQ, 32'h7fff_ffff, 4'd0);
        send_op(FUNC_ENQ, 32'h0000_0000, 4'd0);
        send_op(FUNC_ENQ, 32'hffff_ffff, 4'd0);
        send_op(FUNC_ENQ, 32'h0000_0005, 4'd0);
        send_op(FUNC_ENQ, 32'h0000_0005, 4'd0);
        send_op(FUNC_ENQ, 32'ha5a5_a5a5, 4'd0);
        send_op(FUNC_ENQ, 32'h5a5a_5a5a, 4'd0);
        for (int i = 0; i < DEPTH - 8; i++) begin
            send_op(FUNC_ENQ, 32'h100 + i, 4'd0);
        end
        send_op(FUNC_ENQ, 32'h1234_5678, 4'd15);
    endtask

    task automatic test_search_and_read();
        send_op(FUNC_SEARCH, 32'h0000_0005, 4'd0);
        send_op(FUNC_SEARCH, 32'h1234_5678, 4'd0);
        send_op(FUNC_READ, 32'h0, 4'd15);
        send_op(FUNC_DEQ, 32'h0, 4'd0);
        send_op(FUNC_READ, 32'h0, 4'd15);
    endtask

    task automatic test_receiver_holdoff();
        send_idle_pct = 0;
        @(negedge aclk);
        stall_left = 300;
        @(posedge aclk);
        for (int i = 0; i < 20; i++) begin
            send_request(random_request(45));
        end
        wait_drained();
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct, input int n_items);
        int enq_pct;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        enq_pct = 55;
        for (int i = 0; i < n_items; i++) begin
            if (i % 40 == 0) begin
                enq_pct = (enq_pct == 55) ? 15 : 55;
            end
            send_request(random_request(enq_pct));
        end
        wait_drained();
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_empty_queue();
        test_fill_to_full();
        test_search_and_read();
        test_receiver_holdoff();
        test_random_traffic(10, 85, 320);
        test_random_traffic(85, 10, 320);
        test_random_traffic(0, 0, 320);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/fqs_pkg.sv
rtl/fqs_ctrl.sv
rtl/fqs_dp.sv
rtl/fifo_queue_with_search.sv
bench/fifo_queue_with_search_test.sv
